FILE: src/kicker_stroke_overcurrent_ctrl_defines.svh
// Assertion macros for the kicker stroke over-current controller.
// Used by kicker_stroke_overcurrent_ctrl.sv; expects clk and rst in scope.
`ifndef KICKER_STROKE_OVERCURRENT_CTRL_DEFINES_SVH
`define KICKER_STROKE_OVERCURRENT_CTRL_DEFINES_SVH
`ifndef ASSERT_OFF
`define KSOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KSOC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define KSOC_ASSERT(label, prop, msg)
`define KSOC_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

FILE: src/ksoc_pkg.sv
// Package for the kicker stroke over-current controller.
// Holds register indexes, stage encoding, widths, reset defaults and the duty helper.
// No dependencies.
package ksoc_pkg;

  localparam int AdcBits    = 10;
  localparam int CfgIdxBits = 3;
  localparam int CfgBits    = 16;
  localparam int StampBits  = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    RegTripLevel    = 3'd0,
    RegPulseWidth   = 3'd1,
    RegTripDelay    = 3'd2,
    RegDwell        = 3'd3,
    RegRecoverIdle  = 3'd4,
    RegRecoverRun   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    StCheckHome = 4'b0001,
    StToLimit   = 4'b0010,
    StBackHome  = 4'b0100,
    StFinished  = 4'b1000
  } stage_t;

  localparam logic [AdcBits-1:0] TripLevelDefault    = 10'd1023;
  localparam logic [7:0]         PulseWidthDefault   = 8'd255;
  localparam logic [15:0]        TripDelayDefault    = 16'd40;
  localparam logic [15:0]        DwellDefault        = 16'd500;
  localparam logic [15:0]        RecoverIdleDefault  = 16'd500;
  localparam logic [15:0]        RecoverRunDefault   = 16'd300;

  // floor(x / 3) * 2 through x * 171 >> 9, exact for 8-bit x
  function automatic logic [7:0] two_thirds(input logic [7:0] pw);
    logic [16:0] prod;
    logic [7:0]  third;
    prod  = 17'(pw) * 17'd171;
    third = prod[16:9];
    return {third[6:0], 1'b0};
  endfunction

endpackage

FILE: src/kicker_stroke_overcurrent_ctrl.sv
// Top level of the kicker stroke controller with over-current trip.
// Depends on ksoc_pkg and kicker_stroke_overcurrent_ctrl_defines.svh.
//
// One control tick is one input transfer; its result appears in the next cycle
// and a new tick is taken every cycle unless the result is stalled. The whole
// tick (stroke sequencing, dwell and trip timing, alarm and recovery) is one
// pass of compare logic into the state and output registers, so the result
// register is the only stage; one tick per clock unless the result is stalled.
`include "kicker_stroke_overcurrent_ctrl_defines.svh"

module kicker_stroke_overcurrent_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ksoc_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [ksoc_pkg::CfgBits-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            handle_on,
  input  logic                            home_raw,
  input  logic                            limit_raw,
  input  logic                            platform_raw,
  input  logic                            clear_request,
  input  logic [ksoc_pkg::AdcBits-1:0]    current_code,
  input  logic [ksoc_pkg::StampBits-1:0]  now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            drive_forward,
  output logic                            drive_reverse,
  output logic [7:0]                      duty,
  output logic                            alarm_out,
  output logic                            finish_out,
  output logic                            platform_full_out
);

  logic [ksoc_pkg::AdcBits-1:0] trip_level;
  logic [7:0]  pulse_width;
  logic [15:0] trip_delay_ms, dwell_ms, recover_idle_ms, recover_run_ms;

  ksoc_pkg::stage_t stage, stage_next;
  logic        alarm_latched, alarm_latched_next;
  logic [1:0]  trip_count, trip_count_next;
  logic [1:0]  quiet_count, quiet_count_next;
  logic [31:0] quiet_start, quiet_start_next;
  logic [31:0] trip_start, trip_start_next;
  logic [31:0] move_start, move_start_next;
  logic        finished_flag, finished_flag_next;
  logic        out_forward, out_forward_next;
  logic        out_reverse, out_reverse_next;
  logic [7:0]  out_duty, out_duty_next;
  logic        out_finish, out_finish_next;
  logic        out_platform, out_platform_next;

  logic        accept;
  logic        home, limit, platform;
  logic [15:0] recover_period;
  logic [31:0] quiet_elapsed, trip_elapsed, move_elapsed;
  logic [7:0]  duty_reduced;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign home     = ~home_raw;
  assign limit    = ~limit_raw;
  assign platform = ~platform_raw;

  assign recover_period = handle_on ? recover_run_ms : recover_idle_ms;
  assign quiet_elapsed  = now_ms - quiet_start;
  assign trip_elapsed   = now_ms - trip_start;
  assign move_elapsed   = now_ms - move_start;
  assign duty_reduced   = ksoc_pkg::two_thirds(pulse_width);

  always_comb begin
    stage_next         = stage;
    alarm_latched_next = alarm_latched;
    trip_count_next    = trip_count;
    quiet_count_next   = quiet_count;
    quiet_start_next   = quiet_start;
    trip_start_next    = trip_start;
    move_start_next    = move_start;
    finished_flag_next = finished_flag;
    out_forward_next   = out_forward;
    out_reverse_next   = out_reverse;
    out_duty_next      = out_duty;
    out_finish_next    = out_finish;
    out_platform_next  = out_platform;

    // recovery and current check
    if (~handle_on || ~alarm_latched) begin
      if (trip_count != 2'd0 && ~alarm_latched) begin
        if (quiet_count != 2'd2) begin
          quiet_count_next = quiet_count + 2'd1;
        end
        if (quiet_count == 2'd0) begin
          quiet_start_next = now_ms;
        end else if (quiet_elapsed > 32'(recover_period)) begin
          trip_count_next  = 2'd0;
          quiet_count_next = 2'd0;
        end
      end
      if (current_code >= trip_level) begin
        if (trip_count_next != 2'd2) begin
          trip_count_next = trip_count_next + 2'd1;
        end
        if (trip_count_next <= 2'd1) begin
          trip_start_next = now_ms;
        end else if (trip_elapsed > 32'(trip_delay_ms)) begin
          alarm_latched_next = 1'b1;
          out_duty_next      = 8'd0;
          if (~handle_on) begin
            out_forward_next = 1'b0;
            out_reverse_next = 1'b0;
          end
        end
      end
    end

    if (handle_on) begin
      if (~alarm_latched_next) begin
        out_platform_next = platform;
        if (platform) begin
          out_duty_next = 8'd0;
        end else begin
          case (stage)
            ksoc_pkg::StCheckHome: begin
              if (~home) begin
                out_forward_next = 1'b0;
                out_reverse_next = 1'b1;
                out_duty_next    = pulse_width;
              end else begin
                stage_next       = ksoc_pkg::StToLimit;
                out_forward_next = 1'b1;
                out_reverse_next = 1'b0;
                out_duty_next    = duty_reduced;
                move_start_next  = now_ms;
              end
            end
            ksoc_pkg::StToLimit: begin
              if (move_elapsed > 32'(dwell_ms)) begin
                if (~limit) begin
                  out_forward_next = 1'b1;
                  out_reverse_next = 1'b0;
                  out_duty_next    = pulse_width;
                end else begin
                  stage_next       = ksoc_pkg::StBackHome;
                  out_forward_next = 1'b0;
                  out_reverse_next = 1'b1;
                  out_duty_next    = duty_reduced;
                  move_start_next  = now_ms;
                end
              end
            end
            ksoc_pkg::StBackHome: begin
              if (move_elapsed > 32'(dwell_ms)) begin
                if (~home) begin
                  out_forward_next = 1'b0;
                  out_reverse_next = 1'b1;
                  out_duty_next    = pulse_width;
                end else begin
                  stage_next    = ksoc_pkg::StFinished;
                  out_duty_next = 8'd0;
                end
              end
            end
            default: begin
              finished_flag_next = 1'b1;
              out_duty_next      = pulse_width;
              out_finish_next    = 1'b1;
              out_forward_next   = 1'b0;
              out_reverse_next   = ~home;
            end
          endcase
        end
      end
    end else begin
      stage_next        = ksoc_pkg::StCheckHome;
      out_platform_next = platform;
      if (~alarm_latched_next) begin
        if (finished_flag) begin
          out_finish_next = 1'b0;
        end
        finished_flag_next = 1'b0;
        out_duty_next      = pulse_width;
        out_forward_next   = 1'b0;
        out_reverse_next   = ~home;
      end else if (clear_request) begin
        out_finish_next    = 1'b0;
        out_duty_next      = pulse_width;
        alarm_latched_next = 1'b0;
        finished_flag_next = 1'b0;
        trip_count_next    = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_level      <= ksoc_pkg::TripLevelDefault;
      pulse_width     <= ksoc_pkg::PulseWidthDefault;
      trip_delay_ms   <= ksoc_pkg::TripDelayDefault;
      dwell_ms        <= ksoc_pkg::DwellDefault;
      recover_idle_ms <= ksoc_pkg::RecoverIdleDefault;
      recover_run_ms  <= ksoc_pkg::RecoverRunDefault;
    end else if (cfg_write) begin
      case (cfg_index)
        ksoc_pkg::RegTripLevel:   trip_level      <= cfg_data[ksoc_pkg::AdcBits-1:0];
        ksoc_pkg::RegPulseWidth:  pulse_width     <= cfg_data[7:0];
        ksoc_pkg::RegTripDelay:   trip_delay_ms   <= cfg_data;
        ksoc_pkg::RegDwell:       dwell_ms        <= cfg_data;
        ksoc_pkg::RegRecoverIdle: recover_idle_ms <= cfg_data;
        ksoc_pkg::RegRecoverRun:  recover_run_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      stage         <= ksoc_pkg::StCheckHome;
      alarm_latched <= 1'b0;
      trip_count    <= 2'd0;
      quiet_count   <= 2'd0;
      quiet_start   <= '0;
      trip_start    <= '0;
      move_start    <= '0;
      finished_flag <= 1'b0;
      out_forward   <= 1'b0;
      out_reverse   <= 1'b0;
      out_duty      <= 8'd0;
      out_finish    <= 1'b0;
      out_platform  <= 1'b0;
    end else begin
      if (accept) begin
        out_valid     <= 1'b1;
        stage         <= stage_next;
        alarm_latched <= alarm_latched_next;
        trip_count    <= trip_count_next;
        quiet_count   <= quiet_count_next;
        quiet_start   <= quiet_start_next;
        trip_start    <= trip_start_next;
        move_start    <= move_start_next;
        finished_flag <= finished_flag_next;
        out_forward   <= out_forward_next;
        out_reverse   <= out_reverse_next;
        out_duty      <= out_duty_next;
        out_finish    <= out_finish_next;
        out_platform  <= out_platform_next;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign drive_forward     = out_forward;
  assign drive_reverse     = out_reverse;
  assign duty              = out_duty;
  assign alarm_out         = alarm_latched;
  assign finish_out        = out_finish;
  assign platform_full_out = out_platform;

  `KSOC_ASSERT(a_dir_exclusive, !(out_forward && out_reverse), "both directions driven")
  `KSOC_ASSERT_IMP(a_alarm_no_duty, alarm_latched, out_duty == 8'd0, "duty nonzero under alarm")
  `KSOC_ASSERT_IMP(a_alarm_needs_trips, $rose(alarm_latched), trip_count == 2'd2,
    "alarm latched without two trips")
  `KSOC_ASSERT_IMP(a_trip_sat, 1'b1, trip_count != 2'd3 && quiet_count != 2'd3,
    "counter past saturation")

endmodule

FILE: dv/tb_top.sv
// Testbench for kicker_stroke_overcurrent_ctrl: directed and random control ticks.
// A stroke board object predicts each tick's outputs and checks the block's results.
// Depends on ksoc_pkg and the RTL top level only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic                           handle_on;
    logic                           home_raw;
    logic                           limit_raw;
    logic                           platform_raw;
    logic                           clear_request;
    logic [ksoc_pkg::AdcBits-1:0]   current_code;
    logic [ksoc_pkg::StampBits-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic       drive_forward;
    logic       drive_reverse;
    logic [7:0] duty;
    logic       alarm_out;
    logic       finish_out;
    logic       platform_full_out;
  } outputs_t;

  typedef struct {
    logic [15:0] trip_level;
    logic [15:0] pulse_width;
    logic [15:0] trip_delay;
    logic [15:0] dwell;
    logic [15:0] recover_idle;
    logic [15:0] recover_run;
  } reg_set_t;

  class stroke_board;
    logic [ksoc_pkg::AdcBits-1:0] trip_level   = 10'd1023;
    logic [7:0]                   pulse_width  = 8'd255;
    logic [15:0]                  trip_delay   = 16'd40;
    logic [15:0]                  dwell        = 16'd500;
    logic [15:0]                  recover_idle = 16'd500;
    logic [15:0]                  recover_run  = 16'd300;

    ksoc_pkg::stage_t stage    = ksoc_pkg::StCheckHome;
    logic        alarm    = 1'b0;
    logic        finished = 1'b0;
    int unsigned trip_cnt = 0;
    int unsigned quiet_cnt = 0;
    logic [31:0] quiet_t0 = '0;
    logic [31:0] trip_t0  = '0;
    logic [31:0] move_t0  = '0;
    outputs_t    outs     = '0;

    outputs_t expected_outputs[$];
    int       mismatches = 0;
    int       checked    = 0;

    function void set_reg(ksoc_pkg::cfg_reg_t idx, logic [15:0] v);
      case (idx)
        ksoc_pkg::RegTripLevel:   trip_level   = v[ksoc_pkg::AdcBits-1:0];
        ksoc_pkg::RegPulseWidth:  pulse_width  = v[7:0];
        ksoc_pkg::RegTripDelay:   trip_delay   = v;
        ksoc_pkg::RegDwell:       dwell        = v;
        ksoc_pkg::RegRecoverIdle: recover_idle = v;
        ksoc_pkg::RegRecoverRun:  recover_run  = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] since(logic [31:0] now, logic [31:0] t0);
      return now - t0;
    endfunction

    function logic [7:0] reduced_duty();
      return 8'((int'(pulse_width) / 3) * 2);
    endfunction

    function void home_or_stop(logic home);
      outs.drive_forward = 1'b0;
      outs.drive_reverse = !home;
    endfunction

    function void set_dir(logic fwd, logic rev);
      outs.drive_forward = fwd;
      outs.drive_reverse = rev;
    endfunction

    function void settle_trips(logic [31:0] now, logic [15:0] period);
      if (trip_cnt > 0 && !alarm) begin
        if (quiet_cnt < 2) quiet_cnt++;
        if (quiet_cnt <= 1) begin
          quiet_t0 = now;
        end else if (since(now, quiet_t0) > {16'd0, period}) begin
          trip_cnt  = 0;
          quiet_cnt = 0;
        end
      end
    endfunction

    function void watch_current(logic [31:0] now, logic [ksoc_pkg::AdcBits-1:0] code,
                                logic stop);
      if (code >= trip_level) begin
        if (trip_cnt < 2) trip_cnt++;
        if (trip_cnt <= 1) begin
          trip_t0 = now;
        end else if (since(now, trip_t0) > {16'd0, trip_delay}) begin
          alarm     = 1'b1;
          outs.duty = 8'd0;
          if (stop) set_dir(1'b0, 1'b0);
        end
      end
    endfunction

    function void note_tick(tick_t t);
      logic home;
      logic limit;
      logic full;
      home  = !t.home_raw;
      limit = !t.limit_raw;
      full  = !t.platform_raw;
      if (t.handle_on) begin
        if (!alarm) begin
          settle_trips(t.now_ms, recover_run);
          watch_current(t.now_ms, t.current_code, 1'b0);
        end
        if (!alarm) begin
          outs.platform_full_out = full;
          if (full) begin
            outs.duty = 8'd0;
          end else begin
            case (stage)
              ksoc_pkg::StCheckHome: begin
                if (!home) begin
                  set_dir(1'b0, 1'b1);
                  outs.duty = pulse_width;
                end else begin
                  stage = ksoc_pkg::StToLimit;
                  set_dir(1'b1, 1'b0);
                  outs.duty = reduced_duty();
                  move_t0 = t.now_ms;
                end
              end
              ksoc_pkg::StToLimit: begin
                if (since(t.now_ms, move_t0) > {16'd0, dwell}) begin
                  if (!limit) begin
                    set_dir(1'b1, 1'b0);
                    outs.duty = pulse_width;
                  end else begin
                    stage = ksoc_pkg::StBackHome;
                    set_dir(1'b0, 1'b1);
                    outs.duty = reduced_duty();
                    move_t0 = t.now_ms;
                  end
                end
              end
              ksoc_pkg::StBackHome: begin
                if (since(t.now_ms, move_t0) > {16'd0, dwell}) begin
                  if (!home) begin
                    set_dir(1'b0, 1'b1);
                    outs.duty = pulse_width;
                  end else begin
                    stage = ksoc_pkg::StFinished;
                    outs.duty = 8'd0;
                  end
                end
              end
              default: begin
                finished = 1'b1;
                outs.duty = pulse_width;
                outs.finish_out = 1'b1;
                home_or_stop(home);
              end
            endcase
          end
        end
      end else begin
        stage = ksoc_pkg::StCheckHome;
        settle_trips(t.now_ms, recover_idle);
        outs.platform_full_out = full;
        watch_current(t.now_ms, t.current_code, 1'b1);
        if (!alarm) begin
          if (finished) outs.finish_out = 1'b0;
          finished  = 1'b0;
          outs.duty = pulse_width;
          home_or_stop(home);
        end else if (t.clear_request) begin
          outs.finish_out = 1'b0;
          outs.duty = pulse_width;
          alarm     = 1'b0;
          finished  = 1'b0;
          trip_cnt  = 0;
        end
      end
      outs.alarm_out = alarm;
      expected_outputs.push_back(outs);
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("ERROR at %0t: result %0d: %s", $time, checked, msg);
      mismatches++;
    endtask

    task check_outputs(outputs_t got);
      outputs_t want;
      if (expected_outputs.size() == 0) begin
        report("result with no tick waiting");
        return;
      end
      want = expected_outputs.pop_front();
      if (got.drive_forward !== want.drive_forward)
        report($sformatf("drive_forward %b, want %b", got.drive_forward, want.drive_forward));
      if (got.drive_reverse !== want.drive_reverse)
        report($sformatf("drive_reverse %b, want %b", got.drive_reverse, want.drive_reverse));
      if (got.duty !== want.duty)
        report($sformatf("duty %0d, want %0d", got.duty, want.duty));
      if (got.alarm_out !== want.alarm_out)
        report($sformatf("alarm_out %b, want %b", got.alarm_out, want.alarm_out));
      if (got.finish_out !== want.finish_out)
        report($sformatf("finish_out %b, want %b", got.finish_out, want.finish_out));
      if (got.platform_full_out !== want.platform_full_out)
        report($sformatf("platform_full_out %b, want %b",
                         got.platform_full_out, want.platform_full_out));
      checked++;
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [ksoc_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [ksoc_pkg::CfgBits-1:0]    cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            handle_on = 1'b0;
  logic                            home_raw = 1'b1;
  logic                            limit_raw = 1'b1;
  logic                            platform_raw = 1'b1;
  logic                            clear_request = 1'b0;
  logic [ksoc_pkg::AdcBits-1:0]    current_code = '0;
  logic [ksoc_pkg::StampBits-1:0]  now_ms = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            drive_forward;
  logic                            drive_reverse;
  logic [7:0]                      duty;
  logic                            alarm_out;
  logic                            finish_out;
  logic                            platform_full_out;

  stroke_board sb = new;

  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          rx_hold = 0;
  int          pos = 0;
  logic [31:0] stamp = '0;

  kicker_stroke_overcurrent_ctrl uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .handle_on         (handle_on),
    .home_raw          (home_raw),
    .limit_raw         (limit_raw),
    .platform_raw      (platform_raw),
    .clear_request     (clear_request),
    .current_code      (current_code),
    .now_ms            (now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .drive_forward     (drive_forward),
    .drive_reverse     (drive_reverse),
    .duty              (duty),
    .alarm_out         (alarm_out),
    .finish_out        (finish_out),
    .platform_full_out (platform_full_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // check each result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_outputs({drive_forward, drive_reverse, duty, alarm_out, finish_out,
                        platform_full_out});
  end

  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
        if (rx_gaps && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 18);
      end
    end
  end

  function automatic tick_t tick_of(bit h, bit hr, bit lr, bit pr, bit cl,
                                    logic [ksoc_pkg::AdcBits-1:0] code, logic [31:0] now);
    tick_t t;
    t.handle_on     = h;
    t.home_raw      = hr;
    t.limit_raw     = lr;
    t.platform_raw  = pr;
    t.clear_request = cl;
    t.current_code  = code;
    t.now_ms        = now;
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    @(negedge clk);
    in_valid      <= 1'b1;
    handle_on     <= t.handle_on;
    home_raw      <= t.home_raw;
    limit_raw     <= t.limit_raw;
    platform_raw  <= t.platform_raw;
    clear_request <= t.clear_request;
    current_code  <= t.current_code;
    now_ms        <= t.now_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input ksoc_pkg::cfg_reg_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic load_settings(input reg_set_t s);
    wait_results();
    write_reg(ksoc_pkg::RegTripLevel, s.trip_level);
    write_reg(ksoc_pkg::RegPulseWidth, s.pulse_width);
    write_reg(ksoc_pkg::RegTripDelay, s.trip_delay);
    write_reg(ksoc_pkg::RegDwell, s.dwell);
    write_reg(ksoc_pkg::RegRecoverIdle, s.recover_idle);
    write_reg(ksoc_pkg::RegRecoverRun, s.recover_run);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic reg_set_t pick_settings(input int phase);
    reg_set_t s;
    case (phase)
      0: s = '{16'd600, 16'd255, 16'd30, 16'd40, 16'd100, 16'd80};
      1: s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      2: s = '{16'd1023, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      default: begin
        s.trip_level   = 16'($urandom_range(300, 1023));
        s.pulse_width  = 16'($urandom_range(0, 255));
        s.trip_delay   = 16'($urandom_range(0, 100));
        s.dwell        = 16'($urandom_range(0, 120));
        s.recover_idle = 16'($urandom_range(0, 200));
        s.recover_run  = 16'($urandom_range(0, 200));
      end
    endcase
    return s;
  endfunction

  task automatic run_directed();
    tick_t seq[$];
    seq.push_back(tick_of(0, 1, 1, 1, 0, 10'd0, 32'd0));
    seq.push_back(tick_of(1, 1, 1, 1, 0, 10'd5, 32'd10));
    seq.push_back(tick_of(1, 0, 1, 1, 0, 10'd5, 32'd20));
    seq.push_back(tick_of(1, 0, 1, 0, 0, 10'd5, 32'd30));
    seq.push_back(tick_of(1, 1, 0, 1, 0, 10'd5, 32'd600));
    seq.push_back(tick_of(1, 1, 1, 1, 0, 10'd5, 32'd1200));
    seq.push_back(tick_of(1, 0, 1, 1, 0, 10'd5, 32'd1300));
    seq.push_back(tick_of(1, 0, 1, 1, 0, 10'd5, 32'd1310));
    seq.push_back(tick_of(1, 1, 1, 1, 0, 10'd5, 32'd1320));
    seq.push_back(tick_of(0, 1, 1, 1, 0, 10'd5, 32'd1330));
    seq.push_back(tick_of(1, 1, 1, 1, 0, 10'd1023, 32'hFFFF_FFF0));
    seq.push_back(tick_of(1, 1, 1, 1, 0, 10'd1023, 32'h0000_0010));
    seq.push_back(tick_of(1, 1, 1, 1, 0, 10'd1023, 32'h0000_0030));
    seq.push_back(tick_of(1, 0, 0, 0, 1, 10'd0, 32'h0000_0040));
    seq.push_back(tick_of(0, 1, 1, 1, 0, 10'd0, 32'h0000_0050));
    seq.push_back(tick_of(0, 1, 1, 1, 1, 10'd0, 32'h0000_0060));
    seq.push_back(tick_of(0, 0, 1, 1, 0, 10'd1023, 32'h0000_0100));
    seq.push_back(tick_of(0, 0, 1, 1, 0, 10'd0, 32'h0000_0200));
    seq.push_back(tick_of(0, 0, 1, 1, 0, 10'd0, 32'h0000_0458));
    seq.push_back(tick_of(0, 1, 0, 0, 1, 10'd512, 32'h7FFF_FFFF));
    seq.push_back(tick_of(1, 0, 0, 1, 0, 10'd1022, 32'hFFFF_FFFF));
    foreach (seq[i]) begin
      if ($urandom_range(0, 3) == 0) idle_in($urandom_range(1, 18));
      send_tick(seq[i]);
    end
    stamp = 32'hFFFF_FFFF;
  endtask

  task automatic run_ticks(input int count, input bit hold_rx, input bit pause_mid);
    tick_t t;
    int    left;
    bit    handle;
    bit    overload;
    left     = 0;
    handle   = 1'b0;
    overload = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (left == 0) begin
        handle   = !handle;
        left     = handle ? $urandom_range(5, 60) : $urandom_range(1, 12);
        overload = handle ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 5) == 0);
      end
      left--;
      case ($urandom_range(0, 19))
        0:       stamp = $urandom;
        1, 2, 3: stamp = stamp + 32'($urandom_range(0, 1000));
        default: stamp = stamp + 32'($urandom_range(0, 40));
      endcase
      if ($urandom_range(0, 11) == 0) begin
        // noise tick
        t = tick_of($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1),
                    10'($urandom_range(0, 1023)), $urandom);
      end else begin
        t.handle_on     = handle;
        t.home_raw      = (pos != 0) ^ ($urandom_range(0, 19) == 0);
        t.limit_raw     = (pos != 3) ^ ($urandom_range(0, 19) == 0);
        t.platform_raw  = ($urandom_range(0, 15) != 0);
        t.clear_request = handle ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 4) < 2);
        if (overload || $urandom_range(0, 9) == 0 || sb.trip_level == 0)
          t.current_code = 10'($urandom_range(sb.trip_level, 1023));
        else
          t.current_code = 10'($urandom_range(0, sb.trip_level - 1));
        t.now_ms = stamp;
      end
      if (hold_rx && k == count / 3) rx_hold = 300;
      if (pause_mid && k == count / 2) wait_results();
      if (tx_gaps && $urandom_range(0, 7) == 0) idle_in($urandom_range(1, 18));
      send_tick(t);
      // advance the kicker along the predicted drive
      if (sb.outs.duty != 0 && $urandom_range(0, 1) == 1) begin
        if (sb.outs.drive_forward && pos < 3) pos++;
        else if (sb.outs.drive_reverse && pos > 0) pos--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (int phase = 0; phase < 8; phase++) begin
      load_settings(pick_settings(phase));
      tx_gaps = (phase % 3 != 1) && (phase != 7);
      rx_gaps = (phase % 3 != 2) && (phase != 7);
      run_ticks(125, phase == 3, phase == 5);
    end
    wait_results();
    if (sb.mismatches == 0 && sb.expected_outputs.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/ksoc_pkg.sv
src/kicker_stroke_overcurrent_ctrl.sv
dv/tb_top.sv
